[src/mtqsd_pkg.sv]
package mtqsd_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 64;
  localparam int PTR_W      = $clog2(RING_DEPTH);

  // Field widths
  localparam int BYTE_W = 8;
  localparam int OP_W   = 2;
  localparam int CNT_W  = 8;
  localparam int HW_W   = 6;
  localparam int SENT_W = 16;

  // Common width for comparing the peak fill against the reported ceiling
  localparam int CMP_W  = (PTR_W > HW_W) ? PTR_W : HW_W;
  localparam int HW_MAX = (1 << HW_W) - 1;

  // Byte constants
  localparam logic [BYTE_W-1:0] DATA_MASK   = 8'h7F;
  localparam logic [BYTE_W-1:0] DEDUP_MAX   = 8'hBF;
  localparam logic [BYTE_W-1:0] CHANNEL_MAX = 8'h0F;
  localparam logic [CNT_W-1:0]  COUNT_MAX   = 8'hFF;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_DEDUP = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_STATUS = 2'd0,
    OP_DATA   = 2'd1,
    OP_TAKE   = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef struct packed {
    logic exec;
  } ctrl_cmd_t;

endpackage

[src/mtqsd_ifs.sv]
interface mtqsd_in_if;
  import mtqsd_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [BYTE_W-1:0] status_byte;
  logic [BYTE_W-1:0] channel;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, opcode, status_byte, channel, data_byte, input ready);
  modport sink (input valid, opcode, status_byte, channel, data_byte, output ready);
endinterface

interface mtqsd_out_if;
  import mtqsd_pkg::*;

  logic              valid;
  logic              ready;
  logic              tx_valid;
  logic [BYTE_W-1:0] tx_byte;
  logic              queued;
  logic [CNT_W-1:0]  overflow_count;
  logic [HW_W-1:0]   high_water;
  logic [SENT_W-1:0] sent_count;

  modport source (output valid, tx_valid, tx_byte, queued, overflow_count, high_water,
                  sent_count, input ready);
  modport sink (input valid, tx_valid, tx_byte, queued, overflow_count, high_water,
                sent_count, output ready);
endinterface

[src/mtqsd_regs.sv]
module mtqsd_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mtqsd_pkg::CFG_AW-1:0] paddr,
  input  logic [mtqsd_pkg::CFG_DW-1:0] pwdata,
  output logic [mtqsd_pkg::CFG_DW-1:0] prdata,
  output logic                        dedup_en
);
  import mtqsd_pkg::*;

  logic dedup_r;
  logic dedup_nxt;
  logic wr_en;

  // Decode the access phase of a write
  always_comb begin
    wr_en     = psel && penable && pwrite;
    dedup_nxt = dedup_r;
    if (wr_en && (paddr[2] == REG_DEDUP)) begin
      dedup_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dedup_r <= 1'b0;
    end else begin
      dedup_r <= dedup_nxt;
    end
  end

  // Read back the register, zero elsewhere
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DEDUP) begin
      prdata = {{(CFG_DW-1){1'b0}}, dedup_r};
    end
  end

  assign dedup_en = dedup_r;

endmodule

[src/mtqsd_ctrl.sv]
module mtqsd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mtqsd_pkg::ctrl_cmd_t cmd
);
  import mtqsd_pkg::*;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_HOLD  = 2'b10
  } ctrl_state_t;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  // Track whether the result register holds a word
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_EMPTY: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        if (out_ready && !in_valid) begin
          state_nxt = ST_EMPTY;
        end
      end
      default: begin
        state_nxt = ST_EMPTY;
      end
    endcase
    cmd.exec = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/mtqsd_dp.sv]
module mtqsd_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mtqsd_pkg::ctrl_cmd_t         cmd,
  input  logic                         dedup_en,
  input  logic [mtqsd_pkg::OP_W-1:0]   opcode,
  input  logic [mtqsd_pkg::BYTE_W-1:0] status_byte,
  input  logic [mtqsd_pkg::BYTE_W-1:0] channel,
  input  logic [mtqsd_pkg::BYTE_W-1:0] data_byte,
  output logic                         tx_valid,
  output logic [mtqsd_pkg::BYTE_W-1:0] tx_byte,
  output logic                         queued,
  output logic [mtqsd_pkg::CNT_W-1:0]  overflow_count,
  output logic [mtqsd_pkg::HW_W-1:0]   high_water,
  output logic [mtqsd_pkg::SENT_W-1:0] sent_count
);
  import mtqsd_pkg::*;

  function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
    next_pos = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  logic [PTR_W-1:0]  wr_pos_r, wr_pos_nxt;
  logic [PTR_W-1:0]  rd_pos_r, rd_pos_nxt;
  logic [BYTE_W-1:0] last_status_r, last_status_nxt;
  logic [CNT_W-1:0]  drop_r, drop_nxt;
  logic [PTR_W-1:0]  peak_r, peak_nxt;
  logic [SENT_W-1:0] sent_r, sent_nxt;
  logic              res_tx_r, res_tx_nxt;
  logic              res_queued_r, res_queued_nxt;

  logic [BYTE_W-1:0] stat_or;
  logic [BYTE_W-1:0] push_byte;
  logic              status_ok;
  logic              dup;
  logic              push_req;
  logic              full;
  logic              push_ok;
  logic              take_hit;
  logic [PTR_W:0]    fill_wide;
  logic [PTR_W-1:0]  fill_new;
  logic [CMP_W-1:0]  peak_cmp;

  // Work out the effect of the accepted word
  always_comb begin
    stat_or   = (channel <= CHANNEL_MAX) ? (status_byte | channel) : status_byte;
    status_ok = status_byte[BYTE_W-1];
    dup       = dedup_en && (stat_or <= DEDUP_MAX) && (stat_or == last_status_r);
    push_req  = ((opcode == OP_STATUS) && status_ok && !dup) || (opcode == OP_DATA);
    push_byte = (opcode == OP_STATUS) ? stat_or : (data_byte & DATA_MASK);
    full      = (next_pos(wr_pos_r) == rd_pos_r);
    push_ok   = push_req && !full;
    take_hit  = (opcode == OP_TAKE) && (rd_pos_r != wr_pos_r);

    // Fill level before this word
    if (wr_pos_r >= rd_pos_r) begin
      fill_wide = {1'b0, wr_pos_r} - {1'b0, rd_pos_r};
    end else begin
      fill_wide = {1'b0, wr_pos_r} + (PTR_W+1)'(RING_DEPTH) - {1'b0, rd_pos_r};
    end
    fill_new = push_ok ? (fill_wide[PTR_W-1:0] + 1'b1) : fill_wide[PTR_W-1:0];

    wr_pos_nxt      = wr_pos_r;
    rd_pos_nxt      = rd_pos_r;
    last_status_nxt = last_status_r;
    drop_nxt        = drop_r;
    peak_nxt        = peak_r;
    sent_nxt        = sent_r;
    res_tx_nxt      = res_tx_r;
    res_queued_nxt  = res_queued_r;

    if (cmd.exec) begin
      res_tx_nxt     = take_hit;
      res_queued_nxt = push_ok;
      // Remember the last channel status, clear it on system status
      if ((opcode == OP_STATUS) && status_ok && dedup_en) begin
        if (stat_or <= DEDUP_MAX) begin
          if (!dup) begin
            last_status_nxt = stat_or;
          end
        end else begin
          last_status_nxt = '0;
        end
      end
      if (push_req) begin
        if (full) begin
          if (drop_r != COUNT_MAX) begin
            drop_nxt = drop_r + 1'b1;
          end
        end else begin
          wr_pos_nxt = next_pos(wr_pos_r);
        end
        if (fill_new > peak_r) begin
          peak_nxt = fill_new;
        end
      end
      if (take_hit) begin
        rd_pos_nxt = next_pos(rd_pos_r);
        sent_nxt   = sent_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r      <= '0;
      rd_pos_r      <= '0;
      last_status_r <= '0;
      drop_r        <= '0;
      peak_r        <= '0;
      sent_r        <= '0;
      res_tx_r      <= 1'b0;
      res_queued_r  <= 1'b0;
    end else begin
      wr_pos_r      <= wr_pos_nxt;
      rd_pos_r      <= rd_pos_nxt;
      last_status_r <= last_status_nxt;
      drop_r        <= drop_nxt;
      peak_r        <= peak_nxt;
      sent_r        <= sent_nxt;
      res_tx_r      <= res_tx_nxt;
      res_queued_r  <= res_queued_nxt;
    end
  end

  // Ring storage: write on push, registered read on take
  always_ff @(posedge clk) begin
    if (cmd.exec && push_ok) begin
      ring_mem[wr_pos_r] <= push_byte;
    end
    if (cmd.exec && take_hit) begin
      rd_data_r <= ring_mem[rd_pos_r];
    end
  end

  // Present the result; counters hold while the result waits
  always_comb begin
    peak_cmp = CMP_W'(peak_r);
    if (peak_cmp > CMP_W'(HW_MAX)) begin
      high_water = HW_W'(HW_MAX);
    end else begin
      high_water = HW_W'(peak_cmp);
    end
    tx_valid       = res_tx_r;
    tx_byte        = res_tx_r ? rd_data_r : '0;
    queued         = res_queued_r;
    overflow_count = drop_r;
    sent_count     = sent_r;
  end

endmodule

[src/midi_tx_queue_status_dedup.sv]
// MIDI transmit queue with running-status deduplication.
// in_ch carries one word per operation: queue a status byte, queue a data
// byte (bit 7 cleared) or take the next byte for the UART. out_ch returns one
// word for every input word: the taken byte with tx_valid, the queued flag,
// the saturating overflow count, the fill high-water mark and the sent count.
// The ring holds RING_DEPTH-1 bytes; a byte pushed into a full ring is lost
// and counted. The cfg_ port holds dedup_enable at byte address 0; write it
// only while no word is in flight.
// The result word is registered and is valid in the cycle after the input word
// is accepted. One word per cycle while out_ch takes each result, set by the
// single result register and the registered read of the ring memory.
// When out_ch stalls, the result holds and in_ch.ready drops until the result
// is taken; a new word is accepted in the same cycle the old one leaves.
// Synchronous reset empties the ring, clears all counters and the stored
// status, and clears dedup_enable; ring contents are not cleared.
module midi_tx_queue_status_dedup (
  input  logic                         clk,
  input  logic                         rst_n,
  mtqsd_in_if.sink                     in_ch,
  mtqsd_out_if.source                  out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [mtqsd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [mtqsd_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [mtqsd_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                         cfg_pready
);
  import mtqsd_pkg::*;

  ctrl_cmd_t cmd;
  logic      dedup_en;

  assign cfg_pready = 1'b1;

  mtqsd_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .dedup_en (dedup_en)
  );

  mtqsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  mtqsd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .dedup_en       (dedup_en),
    .opcode         (in_ch.opcode),
    .status_byte    (in_ch.status_byte),
    .channel        (in_ch.channel),
    .data_byte      (in_ch.data_byte),
    .tx_valid       (out_ch.tx_valid),
    .tx_byte        (out_ch.tx_byte),
    .queued         (out_ch.queued),
    .overflow_count (out_ch.overflow_count),
    .high_water     (out_ch.high_water),
    .sent_count     (out_ch.sent_count)
  );

endmodule

[src/mtqsd_chk.sv]
module mtqsd_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         tx_valid,
  input logic [mtqsd_pkg::BYTE_W-1:0] tx_byte,
  input logic                         queued,
  input logic [mtqsd_pkg::CNT_W-1:0]  overflow_count,
  input logic [mtqsd_pkg::HW_W-1:0]   high_water,
  input logic [mtqsd_pkg::SENT_W-1:0] sent_count
);
  import mtqsd_pkg::*;

  // A word either takes a byte or queues one, never both
  a_take_or_queue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(tx_valid && queued))
    else $error("result both took and queued a byte");

  // An empty take reports a zero byte
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !tx_valid) |-> (tx_byte == '0))
    else $error("tx_byte not zero without tx_valid");

  // Every accepted word yields a result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("no result after accepted word");

  // Overflow count and high-water mark never fall between resets
  a_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((overflow_count >= $past(overflow_count)) &&
                      (high_water >= $past(high_water))))
    else $error("overflow count or high-water mark decreased");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(tx_valid) && $stable(tx_byte) &&
                                   $stable(queued) && $stable(sent_count)))
    else $error("stalled result changed");

endmodule

bind midi_tx_queue_status_dedup mtqsd_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .tx_valid       (out_ch.tx_valid),
  .tx_byte        (out_ch.tx_byte),
  .queued         (out_ch.queued),
  .overflow_count (out_ch.overflow_count),
  .high_water     (out_ch.high_water),
  .sent_count     (out_ch.sent_count)
);

[tb/sv/midi_queue_checker.sv]
module midi_queue_checker
  import mtqsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  mtqsd_in_if               in_mon,
  mtqsd_out_if              out_mon,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic              cfg_pready,
  output int                fails,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_AW-1:0] DEDUP_ADDR = CFG_AW'(4 * int'(REG_DEDUP));

  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              queued;
    logic [CNT_W-1:0]  overflow_count;
    logic [HW_W-1:0]   high_water;
    logic [SENT_W-1:0] sent_count;
  } tx_word_t;

  // Shadow copy of the transmit queue
  logic [BYTE_W-1:0] ring_copy [RING_DEPTH];
  int                wr_idx;
  int                rd_idx;
  int                peak;
  logic [BYTE_W-1:0] last_stat;
  logic [CNT_W-1:0]  drops;
  logic [SENT_W-1:0] sent_cnt;
  logic              dedup_on;
  tx_word_t          due_words [$];

  // Push one byte; a full ring loses it and bumps the saturating drop count
  function automatic logic push_ring(logic [BYTE_W-1:0] b);
    int   nxt;
    int   fill;
    logic ok;
    ok  = 1'b0;
    nxt = (wr_idx + 1) % RING_DEPTH;
    if (nxt == rd_idx) begin
      if (drops != COUNT_MAX) drops++;
    end else begin
      ring_copy[wr_idx] = b;
      wr_idx = nxt;
      ok = 1'b1;
    end
    fill = (wr_idx - rd_idx + RING_DEPTH) % RING_DEPTH;
    if (fill > peak) peak = fill;
    return ok;
  endfunction

  // Work out the result word for one accepted input word
  function automatic tx_word_t apply_word(opcode_t op, logic [BYTE_W-1:0] st,
                                          logic [BYTE_W-1:0] ch, logic [BYTE_W-1:0] db);
    tx_word_t          r;
    logic [BYTE_W-1:0] s;
    logic              keep;
    r = '0;
    case (op)
      OP_STATUS: begin
        // only bytes with the top bit set are status bytes
        if (st[BYTE_W-1]) begin
          s    = (ch <= CHANNEL_MAX) ? (st | ch) : st;
          keep = 1'b1;
          if (dedup_on) begin
            if (s <= DEDUP_MAX) begin
              if (s == last_stat) keep = 1'b0;
              else last_stat = s;
            end else begin
              last_stat = '0;
            end
          end
          if (keep) r.queued = push_ring(s);
        end
      end
      OP_DATA: r.queued = push_ring(db & DATA_MASK);
      OP_TAKE: begin
        if (rd_idx != wr_idx) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = ring_copy[rd_idx];
          rd_idx     = (rd_idx + 1) % RING_DEPTH;
          sent_cnt++;
        end
      end
      default: ;
    endcase
    r.overflow_count = drops;
    r.high_water     = (peak > HW_MAX) ? HW_W'(HW_MAX) : HW_W'(peak);
    r.sent_count     = sent_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    tx_word_t got;
    tx_word_t want;
    if (!rst_n) begin
      wr_idx    = 0;
      rd_idx    = 0;
      peak      = 0;
      last_stat = '0;
      drops     = '0;
      sent_cnt  = '0;
      dedup_on  = 1'b0;
      due_words.delete();
      fails     = 0;
      pending   = 0;
    end else begin
      // Compare a returned word with the oldest prediction
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        got = '{tx_valid: out_mon.tx_valid, tx_byte: out_mon.tx_byte,
                queued: out_mon.queued, overflow_count: out_mon.overflow_count,
                high_water: out_mon.high_water, sent_count: out_mon.sent_count};
        if (due_words.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected word tx_valid=%0b tx_byte=%02h queued=%0b ovf=%0d hw=%0d sent=%0d",
                     $realtime, got.tx_valid, got.tx_byte, got.queued, got.overflow_count,
                     got.high_water, got.sent_count);
        end else begin
          want = due_words.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display({"%0t: mismatch exp tx_valid=%0b tx_byte=%02h queued=%0b ovf=%0d hw=%0d ",
                        "sent=%0d / got tx_valid=%0b tx_byte=%02h queued=%0b ovf=%0d hw=%0d sent=%0d"},
                       $realtime, want.tx_valid, want.tx_byte, want.queued, want.overflow_count,
                       want.high_water, want.sent_count, got.tx_valid, got.tx_byte, got.queued,
                       got.overflow_count, got.high_water, got.sent_count);
          end
        end
      end
      // Predict the result of an accepted input word
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        due_words.push_back(apply_word(opcode_t'(in_mon.opcode), in_mon.status_byte,
                                       in_mon.channel, in_mon.data_byte));
      // Track register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == DEDUP_ADDR)
        dedup_on = cfg_pwdata[0];
      pending = due_words.size();
    end
  end

endmodule

[tb/sv/tb_midi_tx_queue_status_dedup.sv]
module tb_midi_tx_queue_status_dedup;
  import mtqsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_AW-1:0] DEDUP_ADDR = CFG_AW'(4 * int'(REG_DEDUP));

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_NOISE} mix_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int                fails;
  int                pending;
  bit                quiet;

  mtqsd_in_if  in_ch ();
  mtqsd_out_if out_ch ();

  midi_tx_queue_status_dedup dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  midi_queue_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_pready (cfg_pready),
    .fails      (fails),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    #2_000_000;
    $display("[midi_tx_queue_status_dedup] ERROR");
    $finish;
  end

  // Result side: stall a random number of cycles before each word
  initial begin
    int stall;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
    end
  end

  // Offer one input word after a random gap and hold it until taken
  task automatic send_word(opcode_t op, logic [BYTE_W-1:0] st, logic [BYTE_W-1:0] ch,
                           logic [BYTE_W-1:0] db);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.status_byte <= st;
    in_ch.channel     <= ch;
    in_ch.data_byte   <= db;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Drop valid and let every outstanding word come back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // One random word; status bytes favour a few channel messages so dedup hits
  task automatic send_random(mix_t kind);
    opcode_t           op;
    logic [BYTE_W-1:0] st;
    logic [BYTE_W-1:0] ch;
    int                r;
    r = $urandom_range(0, 99);
    case (kind)
      MIX_FILL:  op = (r < 45) ? OP_STATUS : (r < 85) ? OP_DATA : OP_TAKE;
      MIX_DRAIN: op = (r < 80) ? OP_TAKE : (r < 90) ? OP_STATUS : OP_DATA;
      MIX_EVEN:  op = (r < 35) ? OP_STATUS : (r < 65) ? OP_DATA : OP_TAKE;
      default:   op = opcode_t'($urandom_range(0, 3));
    endcase
    r = $urandom_range(0, 9);
    if (kind == MIX_NOISE) st = BYTE_W'($urandom);
    else if (r < 6)        st = {2'b10, 2'($urandom_range(0, 3)), 4'h0};
    else if (r < 8)        st = BYTE_W'($urandom_range(8'hC0, 8'hFF));
    else                   st = BYTE_W'($urandom_range(0, 8'h7F));
    if (kind == MIX_NOISE || $urandom_range(0, 3) == 0) ch = BYTE_W'($urandom);
    else ch = BYTE_W'($urandom_range(0, 2));
    send_word(op, st, ch, BYTE_W'($urandom));
  endtask

  // Segments of one mix each, some without any idling
  task automatic run_random(int count);
    int   n;
    int   len;
    mix_t kind;
    n = 0;
    while (n < count) begin
      len   = $urandom_range(8, 40);
      if (len > count - n) len = count - n;
      kind  = mix_t'($urandom_range(0, 3));
      quiet = ($urandom_range(0, 3) == 0);
      repeat (len) begin
        send_random(kind);
        n++;
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    quiet             = 1'b0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_NOP;
    in_ch.status_byte<= '0;
    in_ch.channel    <= '0;
    in_ch.data_byte  <= '0;
    cfg_psel         <= 1'b0;
    cfg_penable      <= 1'b0;
    cfg_pwrite       <= 1'b0;
    cfg_paddr        <= '0;
    cfg_pwdata       <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Plain mode: empty take, no-op, ignored status, channel merge, data mask
    write_reg(DEDUP_ADDR, 0);
    send_word(OP_TAKE,   8'h00, 8'h00, 8'h00);
    send_word(OP_NOP,    8'hFF, 8'hFF, 8'hFF);
    send_word(OP_STATUS, 8'h00, 8'h00, 8'h00);
    send_word(OP_STATUS, 8'h7F, 8'h0F, 8'h00);
    send_word(OP_STATUS, 8'h80, 8'h00, 8'h00);
    send_word(OP_STATUS, 8'h80, 8'h0F, 8'h00);
    send_word(OP_STATUS, 8'h90, 8'h10, 8'h00);
    send_word(OP_STATUS, 8'h90, 8'hFF, 8'h00);
    send_word(OP_STATUS, 8'hFF, 8'h00, 8'h00);
    send_word(OP_DATA,   8'h00, 8'h00, 8'hFF);
    send_word(OP_DATA,   8'h00, 8'h00, 8'h00);
    send_word(OP_DATA,   8'h00, 8'h00, 8'h80);
    repeat (9) send_word(OP_TAKE, 8'h00, 8'h00, 8'h00);
    wait_idle();

    // Dedup mode: repeats dropped, system status clears the stored status
    write_reg(DEDUP_ADDR, 1);
    send_word(OP_STATUS, 8'h90, 8'h01, 8'h00);
    send_word(OP_STATUS, 8'h90, 8'h01, 8'h00);
    send_word(OP_STATUS, 8'h91, 8'h20, 8'h00);
    send_word(OP_STATUS, 8'hC0, 8'h00, 8'h00);
    send_word(OP_STATUS, 8'h90, 8'h01, 8'h00);
    send_word(OP_STATUS, 8'hBF, 8'h00, 8'h00);
    send_word(OP_STATUS, 8'hB0, 8'h0F, 8'h00);
    send_word(OP_STATUS, 8'hF0, 8'h05, 8'h00);
    repeat (6) send_word(OP_TAKE, 8'h00, 8'h00, 8'h00);
    wait_idle();

    run_random(40);
    wait_idle();

    // Flood the ring past full until the drop count saturates, then drain it
    write_reg(DEDUP_ADDR, 0);
    quiet = ($urandom_range(0, 1) == 0);
    repeat (330) send_word(OP_DATA, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
    quiet = 1'b0;
    repeat (70) send_word(OP_TAKE, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
    run_random(20);
    wait_idle();

    write_reg(DEDUP_ADDR, 1);
    run_random(20);
    wait_idle();

    if (fails == 0)
      $display("[midi_tx_queue_status_dedup] OK");
    else
      $display("[midi_tx_queue_status_dedup] ERROR");
    $finish;
  end

endmodule
